// ===== hw/rtl/generational_handle_allocator_unit_defines.svh =====
// Assertion macros used by the handle allocator datapath.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is held.
`define GHA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("handle allocator check failed");

// Next-cycle implication, disabled while reset is held.
`define GHA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("handle allocator check failed");

`else

`define GHA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GHA_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hw/rtl/gha_pkg.sv =====
// Shared types and constants of the generational handle allocator.
package gha_pkg;

    localparam int DEFAULT_CAPACITY = 1024;
    // Width that holds any index or count for the largest allowed capacity.
    localparam int WIDE_W   = 17;
    localparam int INDEX_W  = 10;
    localparam int GEN_W    = 32;
    localparam int TOTAL_W  = 11;
    localparam int STATUS_W = 2;

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_CHECK   = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_FULL = 2'd1;
    localparam t_status ST_DEAD = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_POPGEN,
        S_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic pop_addr;
        logic exec;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_pending;
    } t_dp_sts;

endpackage

// ===== hw/rtl/gha_ctrl.sv =====
// Controller state machine of the generational handle allocator.
module gha_ctrl
    import gha_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        o_cmd.capture  = 1'b0;
        o_cmd.pop_addr = 1'b0;
        o_cmd.exec     = 1'b0;
        busy           = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_FETCH;
                end
            end
            S_FETCH: begin
                // A create that pops must first read the freed index.
                if (i_sts.pop_pending) begin
                    n_state = S_POPGEN;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_POPGEN: begin
                o_cmd.pop_addr = 1'b1;
                n_state        = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/gha_dpath.sv =====
// Datapath of the generational handle allocator: tables, counters and result registers.
`include "generational_handle_allocator_unit_defines.svh"

module gha_dpath
    import gha_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic [1:0]          i_cmd_code,
    input  logic [INDEX_W-1:0]  i_in_index,
    input  logic [GEN_W-1:0]    i_in_generation,
    output logic                o_result_valid,
    output logic [INDEX_W-1:0]  o_out_index,
    output logic [GEN_W-1:0]    o_out_generation,
    output logic                o_handle_live,
    output logic [STATUS_W-1:0] o_status,
    output logic [TOTAL_W-1:0]  o_live_total
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [WIDE_W-1:0] CAP_W = WIDE_W'(CAPACITY);

    // Captured request.
    t_cmd               r_cmd;
    logic [INDEX_W-1:0] r_idx;
    logic [GEN_W-1:0]   r_gen;

    // Allocator counters.
    logic [CW-1:0] r_top,   n_top;
    logic [CW-1:0] r_fresh, n_fresh;
    logic [CW-1:0] r_live,  n_live;

    // Tables and their registered read data.
    logic [GEN_W-1:0] mem_gen   [CAPACITY];
    logic [IW-1:0]    mem_stack [CAPACITY];
    logic [GEN_W-1:0] r_gen_rd;
    logic [IW-1:0]    r_stack_rd;

    // Result registers.
    logic                r_valid;
    logic [INDEX_W-1:0]  r_o_idx,    n_o_idx;
    logic [GEN_W-1:0]    r_o_gen,    n_o_gen;
    logic                r_o_live,   n_o_live;
    t_status             r_o_status, n_o_status;

    logic [WIDE_W-1:0] idx_wide;
    logic [WIDE_W-1:0] top_wide;
    logic [WIDE_W-1:0] fresh_wide;
    logic [WIDE_W-1:0] live_wide;
    logic [WIDE_W-1:0] stack_wide;
    logic [CW-1:0]     top_dec;
    logic [IW-1:0]     gen_rd_addr;
    logic              live_hit;
    logic              gen_we;
    logic [IW-1:0]     gen_wa;
    logic [GEN_W-1:0]  gen_wd;
    logic              stk_we;
    logic              full_reported;
    logic              store_exhausted;

    assign idx_wide    = WIDE_W'(r_idx);
    assign top_wide    = WIDE_W'(r_top);
    assign fresh_wide  = WIDE_W'(r_fresh);
    assign live_wide   = WIDE_W'(r_live);
    assign stack_wide  = WIDE_W'(r_stack_rd);
    assign top_dec     = r_top - CW'(1);
    assign gen_rd_addr = i_cmd.pop_addr ? r_stack_rd : idx_wide[IW-1:0];

    assign o_sts.pop_pending = (r_cmd == CMD_CREATE) && (r_top != '0);

    // A handle is live when nonzero, already handed out and matching the table.
    assign live_hit = (r_gen != '0) && (idx_wide < fresh_wide) && (r_gen_rd == r_gen);

    // Request capture on each accepted transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= t_cmd'(i_cmd_code);
            r_idx <= i_in_index;
            r_gen <= i_in_generation;
        end
    end

    // Generation table: one read and one write port.
    always_ff @(posedge i_clk) begin
        r_gen_rd <= mem_gen[gen_rd_addr];
        if (gen_we) begin
            mem_gen[gen_wa] <= gen_wd;
        end
    end

    // Free stack: read at the top entry, pushed on destroy.
    always_ff @(posedge i_clk) begin
        r_stack_rd <= mem_stack[top_dec[IW-1:0]];
        if (stk_we) begin
            mem_stack[r_top[IW-1:0]] <= idx_wide[IW-1:0];
        end
    end

    // Execution of the captured request.
    always_comb begin
        n_top      = r_top;
        n_fresh    = r_fresh;
        n_live     = r_live;
        n_o_idx    = '0;
        n_o_gen    = '0;
        n_o_live   = 1'b0;
        n_o_status = ST_OK;
        gen_we     = 1'b0;
        gen_wa     = idx_wide[IW-1:0];
        gen_wd     = r_gen_rd + GEN_W'(1);
        stk_we     = 1'b0;
        if (i_cmd.exec) begin
            unique case (r_cmd)
                CMD_CREATE: begin
                    if (r_top != '0) begin
                        n_top   = top_dec;
                        n_o_idx = stack_wide[INDEX_W-1:0];
                        n_o_gen = r_gen_rd;
                        n_live  = r_live + CW'(1);
                    end else if (fresh_wide < CAP_W) begin
                        gen_we  = 1'b1;
                        gen_wa  = r_fresh[IW-1:0];
                        gen_wd  = GEN_W'(1);
                        n_o_idx = fresh_wide[INDEX_W-1:0];
                        n_o_gen = GEN_W'(1);
                        n_fresh = r_fresh + CW'(1);
                        n_live  = r_live + CW'(1);
                    end else begin
                        n_o_status = ST_FULL;
                    end
                end
                CMD_DESTROY: begin
                    if (live_hit) begin
                        n_o_live = 1'b1;
                        gen_we   = 1'b1;
                        if (top_wide < CAP_W) begin
                            stk_we = 1'b1;
                            n_top  = r_top + CW'(1);
                        end
                        if (r_live != '0) begin
                            n_live = r_live - CW'(1);
                        end
                    end else begin
                        n_o_status = ST_DEAD;
                    end
                end
                CMD_CHECK: begin
                    n_o_live = live_hit;
                end
                CMD_CLEAR: begin
                    n_top   = '0;
                    n_fresh = '0;
                    n_live  = '0;
                end
                default: begin
                    n_o_status = ST_OK;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= '0;
            r_fresh <= '0;
            r_live  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_top   <= n_top;
            r_fresh <= n_fresh;
            r_live  <= n_live;
            r_valid <= i_cmd.exec;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_o_idx    <= n_o_idx;
            r_o_gen    <= n_o_gen;
            r_o_live   <= n_o_live;
            r_o_status <= n_o_status;
        end
    end

    assign o_result_valid   = r_valid;
    assign o_out_index      = r_o_idx;
    assign o_out_generation = r_o_gen;
    assign o_handle_live    = r_o_live;
    assign o_status         = r_o_status;
    assign o_live_total     = live_wide[TOTAL_W-1:0];

    assign full_reported   = r_valid && (r_o_status == ST_FULL);
    assign store_exhausted = (r_top == '0) && (fresh_wide == CAP_W);

    // The free stack never grows past the capacity.
    `GHA_ASSERT_IMP(a_top_bound, i_clk, i_rst_n, 1'b1, top_wide <= CAP_W)
    // The fresh mark never passes the capacity.
    `GHA_ASSERT_IMP(a_fresh_bound, i_clk, i_rst_n, 1'b1, fresh_wide <= CAP_W)
    // A full report means the store really is exhausted.
    `GHA_ASSERT_IMP(a_full_real, i_clk, i_rst_n, full_reported, store_exhausted)
    // A result strobe lasts a single cycle.
    `GHA_ASSERT_NXT(a_single_strobe, i_clk, i_rst_n, r_valid, !r_valid)

endmodule

// ===== hw/rtl/generational_handle_allocator_unit.sv =====
// Top level of the generational handle allocator.
// A create that reuses a freed slot passes S_FETCH, S_POPGEN and S_EXEC before its result
// strobe, every other command S_FETCH and S_EXEC; the extra state is the dependent read of
// the generation table. Busy stays high until the table update; commands never overlap.
// Each result shows for one cycle on o_result_valid; the receiver cannot stall it.
// Synchronous active-low reset empties the allocator at once; tables need no clearing pass.
module generational_handle_allocator_unit
    import gha_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_cmd,
    input  logic [INDEX_W-1:0]  i_in_index,
    input  logic [GEN_W-1:0]    i_in_generation,
    output logic                o_result_valid,
    output logic [INDEX_W-1:0]  o_out_index,
    output logic [GEN_W-1:0]    o_out_generation,
    output logic                o_handle_live,
    output logic [STATUS_W-1:0] o_status,
    output logic [TOTAL_W-1:0]  o_live_total
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencing of each transfer.
    gha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    // Tables, counters and results.
    gha_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts),
        .i_cmd_code       (i_cmd),
        .i_in_index       (i_in_index),
        .i_in_generation  (i_in_generation),
        .o_result_valid   (o_result_valid),
        .o_out_index      (o_out_index),
        .o_out_generation (o_out_generation),
        .o_handle_live    (o_handle_live),
        .o_status         (o_status),
        .o_live_total     (o_live_total)
    );

endmodule
